/* hdl/sgm_pkg.sv */
// Shared types and constants for the sigmoid gated multiply pipeline.
// Used by every module in hdl/; depends on nothing else.
`timescale 1ns / 1ps

package sgm_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  // saturated negated gate, Q.8
  localparam int X_LIMIT = 88 << FRAC_BITS;
  localparam int X_W     = $clog2(X_LIMIT + 1) + 1;
  localparam int XC_W    = (DATA_WIDTH + 1 > X_W) ? DATA_WIDTH + 1 : X_W;

  // log2(e) in Q.16
  localparam int LOG_W = 18;
  localparam logic signed [LOG_W-1:0] LOG2E_Q16 = LOG_W'(94548);
  localparam int T_W = X_W + LOG_W;

  // exponent split, fraction in Q.24
  localparam int F_W    = 24;
  localparam int HALF_F = 1 << (F_W - 1);
  localparam int N_W    = T_W - F_W;
  localparam logic signed [N_W-1:0] N_HI = N_W'(30);
  localparam logic signed [N_W-1:0] N_LO = N_W'(-20);
  localparam int M_MAX  = 20;
  localparam int SH_W   = 5;

  // polynomial
  localparam int P_W      = 26;
  localparam int PROD_W   = P_W + F_W;
  localparam int HORNER_N = 5;
  localparam logic signed [P_W-1:0] C_FIRST = P_W'(22370);
  localparam logic signed [P_W-1:0] HORNER_ADD [HORNER_N] = '{
    P_W'(161365), P_W'(931204), P_W'(4030332), P_W'(11629080), P_W'(16777216)
  };

  // reciprocal: q = (num + den/2) / den
  localparam int ONE_EXP = 24;
  localparam int NUM_EXP = 40;
  localparam int D_W     = P_W + 31;
  localparam int R_W     = NUM_EXP + M_MAX + 1;
  localparam int Q_BITS  = 17;
  localparam int CMP_W   = D_W + Q_BITS;
  localparam logic [Q_BITS-1:0] Q_LIMIT = Q_BITS'(65536);

  localparam int SIG_W = 16;
  localparam logic [SIG_W-1:0] SIG_MAX = '1;
  localparam int PM_W = DATA_WIDTH + SIG_W + 1;

  // sideband that rides with every beat
  typedef struct packed {
    logic                         valid;
    logic                         row_end;
    logic                         sat_zero;
    logic                         sat_one;
    logic signed [DATA_WIDTH-1:0] data;
  } sgm_tag_t;

endpackage

/* hdl/sgm_front.sv */
// Front end: negate and clamp gate, scale by log2(e), split into integer and fraction.
// Three register stages. Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  sgm_pkg::sgm_tag_t                      tag_i,
  input  logic signed [sgm_pkg::DATA_WIDTH-1:0]  gate_i,
  output sgm_pkg::sgm_tag_t                      tag_o,
  output logic signed [sgm_pkg::N_W-1:0]         n_o,
  output logic signed [sgm_pkg::F_W-1:0]         f_o
);

  localparam logic signed [sgm_pkg::XC_W-1:0] XLIM = sgm_pkg::XC_W'(sgm_pkg::X_LIMIT);

  sgm_pkg::sgm_tag_t tag1_r, tag2_r, tag3_r, tag3_nxt;
  logic signed [sgm_pkg::X_W-1:0]  x_r, x_nxt;
  logic signed [sgm_pkg::T_W-1:0]  t_r, t_nxt, sum;
  logic signed [sgm_pkg::XC_W-1:0] g_ext, neg_g;
  logic signed [sgm_pkg::N_W-1:0]  n_r, n_nxt;
  logic signed [sgm_pkg::F_W-1:0]  f_r, f_nxt;

  always_comb begin
    g_ext = sgm_pkg::XC_W'(gate_i);
    neg_g = -g_ext;
    if (neg_g > XLIM) begin
      x_nxt = sgm_pkg::X_W'(XLIM);
    end else if (neg_g < -XLIM) begin
      x_nxt = sgm_pkg::X_W'(-XLIM);
    end else begin
      x_nxt = sgm_pkg::X_W'(neg_g);
    end
  end

  assign t_nxt = sgm_pkg::T_W'(x_r) * sgm_pkg::T_W'(sgm_pkg::LOG2E_Q16);

  always_comb begin
    sum      = t_r + sgm_pkg::T_W'(sgm_pkg::HALF_F);
    n_nxt    = $signed(sum[sgm_pkg::T_W-1:sgm_pkg::F_W]);
    f_nxt    = $signed({~sum[sgm_pkg::F_W-1], sum[sgm_pkg::F_W-2:0]});
    tag3_nxt = tag2_r;
    tag3_nxt.sat_zero = (n_nxt > sgm_pkg::N_HI);
    tag3_nxt.sat_one  = (n_nxt < sgm_pkg::N_LO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      t_r <= t_nxt;
      n_r <= n_nxt;
      f_r <= f_nxt;
    end
  end

  assign tag_o = tag3_r;
  assign n_o   = n_r;
  assign f_o   = f_r;

endmodule

/* hdl/sgm_poly.sv */
// Degree-5 polynomial for 2^f by Horner's rule, one multiply-add per stage.
// Five register stages. Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_poly (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  sgm_pkg::sgm_tag_t               tag_i,
  input  logic signed [sgm_pkg::N_W-1:0]  n_i,
  input  logic signed [sgm_pkg::F_W-1:0]  f_i,
  output sgm_pkg::sgm_tag_t               tag_o,
  output logic signed [sgm_pkg::N_W-1:0]  n_o,
  output logic signed [sgm_pkg::P_W-1:0]  p_o
);

  sgm_pkg::sgm_tag_t              tag_r [sgm_pkg::HORNER_N];
  logic signed [sgm_pkg::N_W-1:0] n_r   [sgm_pkg::HORNER_N];
  logic signed [sgm_pkg::F_W-1:0] f_r   [sgm_pkg::HORNER_N];
  logic signed [sgm_pkg::P_W-1:0] p_r   [sgm_pkg::HORNER_N];

  for (genvar i = 0; i < sgm_pkg::HORNER_N; i++) begin : g_step
    sgm_pkg::sgm_tag_t                 tag_in;
    logic signed [sgm_pkg::N_W-1:0]    n_in;
    logic signed [sgm_pkg::F_W-1:0]    f_in;
    logic signed [sgm_pkg::P_W-1:0]    p_in, p_nxt;
    logic signed [sgm_pkg::PROD_W-1:0] prod, sum;

    if (i == 0) begin : g_first
      assign tag_in = tag_i;
      assign n_in   = n_i;
      assign f_in   = f_i;
      assign p_in   = sgm_pkg::C_FIRST;
    end else begin : g_next
      assign tag_in = tag_r[i-1];
      assign n_in   = n_r[i-1];
      assign f_in   = f_r[i-1];
      assign p_in   = p_r[i-1];
    end

    always_comb begin
      prod  = sgm_pkg::PROD_W'(p_in) * sgm_pkg::PROD_W'(f_in);
      sum   = prod + sgm_pkg::PROD_W'(sgm_pkg::HALF_F);
      p_nxt = $signed(sum[sgm_pkg::PROD_W-1:sgm_pkg::F_W]) + sgm_pkg::HORNER_ADD[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i] <= '0;
      end else if (en) begin
        tag_r[i] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i] <= n_in;
        f_r[i] <= f_in;
        p_r[i] <= p_nxt;
      end
    end
  end

  assign tag_o = tag_r[sgm_pkg::HORNER_N-1];
  assign n_o   = n_r[sgm_pkg::HORNER_N-1];
  assign p_o   = p_r[sgm_pkg::HORNER_N-1];

endmodule

/* hdl/sgm_div.sv */
// Reciprocal 1/(1+p*2^n) in Q1.16: operand build stage, then restoring
// division one quotient bit per stage. Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  sgm_pkg::sgm_tag_t               tag_i,
  input  logic signed [sgm_pkg::N_W-1:0]  n_i,
  input  logic signed [sgm_pkg::P_W-1:0]  p_i,
  output sgm_pkg::sgm_tag_t               tag_o,
  output logic [sgm_pkg::Q_BITS-1:0]      q_o
);

  localparam int NST = sgm_pkg::Q_BITS + 1;

  sgm_pkg::sgm_tag_t             tag_r [NST];
  logic [sgm_pkg::R_W-1:0]       r_r   [NST];
  logic [sgm_pkg::D_W-1:0]       d_r   [NST];
  logic [sgm_pkg::Q_BITS-1:0]    q_r   [NST];

  logic signed [sgm_pkg::N_W-1:0] neg_n;
  logic [sgm_pkg::SH_W-1:0]       sh;
  logic [sgm_pkg::D_W-1:0]        den;
  logic [sgm_pkg::R_W-1:0]        num;

  // n >= 0: num = 2^40,       den = 2^24 + p*2^n
  // n <  0: num = 2^(40+m),   den = 2^(24+m) + p, m = -n
  always_comb begin
    neg_n = -n_i;
    if (n_i >= 0) begin
      sh  = n_i[sgm_pkg::SH_W-1:0];
      den = (sgm_pkg::D_W'(1) << sgm_pkg::ONE_EXP) + (sgm_pkg::D_W'(p_i) << sh);
      num = sgm_pkg::R_W'(1) << sgm_pkg::NUM_EXP;
    end else begin
      sh  = neg_n[sgm_pkg::SH_W-1:0];
      den = (sgm_pkg::D_W'(1) << (sgm_pkg::ONE_EXP + sh)) + sgm_pkg::D_W'(p_i);
      num = sgm_pkg::R_W'(1) << (sgm_pkg::NUM_EXP + sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= num + sgm_pkg::R_W'(den >> 1);
      d_r[0] <= den;
      q_r[0] <= '0;
    end
  end

  for (genvar j = 1; j < NST; j++) begin : g_bit
    localparam int K = sgm_pkg::Q_BITS - j;
    logic [sgm_pkg::CMP_W-1:0]  r_ext, d_sh;
    logic                       ge;
    logic [sgm_pkg::R_W-1:0]    r_nxt;
    logic [sgm_pkg::Q_BITS-1:0] q_nxt;

    always_comb begin
      r_ext = sgm_pkg::CMP_W'(r_r[j-1]);
      d_sh  = sgm_pkg::CMP_W'(d_r[j-1]) << K;
      ge    = (r_ext >= d_sh);
      r_nxt = ge ? sgm_pkg::R_W'(r_ext - d_sh) : r_r[j-1];
      q_nxt = q_r[j-1];
      q_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[j] <= '0;
      end else if (en) begin
        tag_r[j] <= tag_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j] <= r_nxt;
        d_r[j] <= d_r[j-1];
        q_r[j] <= q_nxt;
      end
    end
  end

  assign tag_o = tag_r[NST-1];
  assign q_o   = q_r[NST-1];

endmodule

/* hdl/sgm_scale.sv */
// Saturate the sigmoid, multiply by data and round to the data format.
// Two register stages; the second is the output register. Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_scale (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  sgm_pkg::sgm_tag_t                      tag_i,
  input  logic [sgm_pkg::Q_BITS-1:0]             q_i,
  output sgm_pkg::sgm_tag_t                      tag_o,
  output logic signed [sgm_pkg::DATA_WIDTH-1:0]  gated_o
);

  localparam int RND = 1 << (sgm_pkg::SIG_W - 1);

  sgm_pkg::sgm_tag_t                     tag_m_r, tag_o_r;
  logic [sgm_pkg::SIG_W-1:0]             sig;
  logic signed [sgm_pkg::PM_W-1:0]       prod_r, prod_nxt, sum;
  logic signed [sgm_pkg::DATA_WIDTH-1:0] out_r, out_nxt;

  always_comb begin
    if (tag_i.sat_zero) begin
      sig = '0;
    end else if (tag_i.sat_one || q_i[sgm_pkg::Q_BITS-1]) begin
      sig = sgm_pkg::SIG_MAX;
    end else begin
      sig = q_i[sgm_pkg::SIG_W-1:0];
    end
    prod_nxt = sgm_pkg::PM_W'(tag_i.data) * sgm_pkg::PM_W'($signed({1'b0, sig}));
  end

  always_comb begin
    sum     = prod_r + sgm_pkg::PM_W'(RND);
    out_nxt = $signed(sum[sgm_pkg::SIG_W +: sgm_pkg::DATA_WIDTH]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_m_r <= '0;
      tag_o_r <= '0;
    end else if (en) begin
      tag_m_r <= tag_i;
      tag_o_r <= tag_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      out_r  <= out_nxt;
    end
  end

  assign tag_o   = tag_o_r;
  assign gated_o = out_r;

endmodule

/* hdl/sigmoid_gated_multiply.sv */
// Top level: sigmoid(gate) * data on a 28-stage pipeline, row end flag passed along.
// Instantiates sgm_front, sgm_poly, sgm_div, sgm_scale; depends on sgm_pkg.
//
//   channel  ports                                        dir
//   input    in_valid in_stall in_gate_value in_data_value in_row_end_in   in
//   result   out_valid out_stall out_gated_value out_row_end_out          out
//
// One beat per cycle in, one per cycle out unless a held output beat stalls the pipe;
// 28 register stages (3 front, 5 polynomial, 18 divider, 2 scale/output).
// The divider stages, one quotient bit each after the operand build stage, set the depth.
// Reset (rst_n low, synchronous) clears the sideband tags, valid bits included; datapath registers are not reset.
// A held output beat freezes every stage; in_stall follows it.
`timescale 1ns / 1ps

module sigmoid_gated_multiply (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sgm_pkg::DATA_WIDTH-1:0]  in_gate_value,
  input  logic signed [sgm_pkg::DATA_WIDTH-1:0]  in_data_value,
  input  logic                                   in_row_end_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [sgm_pkg::DATA_WIDTH-1:0]  out_gated_value,
  output logic                                   out_row_end_out
);

  logic en;

  sgm_pkg::sgm_tag_t              in_tag, front_tag, poly_tag, div_tag, out_tag;
  logic signed [sgm_pkg::N_W-1:0] front_n, poly_n;
  logic signed [sgm_pkg::F_W-1:0] front_f;
  logic signed [sgm_pkg::P_W-1:0] poly_p;
  logic [sgm_pkg::Q_BITS-1:0]     div_q;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    in_tag          = '0;
    in_tag.valid    = in_valid;
    in_tag.row_end  = in_row_end_in;
    in_tag.data     = in_data_value;
  end

  sgm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_i  (in_tag),
    .gate_i (in_gate_value),
    .tag_o  (front_tag),
    .n_o    (front_n),
    .f_o    (front_f)
  );

  sgm_poly u_poly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (front_tag),
    .n_i   (front_n),
    .f_i   (front_f),
    .tag_o (poly_tag),
    .n_o   (poly_n),
    .p_o   (poly_p)
  );

  sgm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (poly_tag),
    .n_i   (poly_n),
    .p_i   (poly_p),
    .tag_o (div_tag),
    .q_o   (div_q)
  );

  sgm_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_i   (div_tag),
    .q_i     (div_q),
    .tag_o   (out_tag),
    .gated_o (out_gated_value)
  );

  assign out_valid       = out_tag.valid;
  assign out_row_end_out = out_tag.row_end;

`ifndef SYNTHESIS
  a_q_range : assert property (@(posedge clk) disable iff (!rst_n)
    div_tag.valid && !div_tag.sat_zero && !div_tag.sat_one |-> div_q <= sgm_pkg::Q_LIMIT)
    else $error("divider quotient out of range");

  a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && div_tag.valid |=> $stable(div_q) && div_tag.valid)
    else $error("pipeline moved while output held");

  a_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tag.sat_zero |-> out_gated_value == '0)
    else $error("saturated-off gate gave nonzero result");
`endif

endmodule
